// ===== rtl/tlbs_pkg.sv =====
// Shared constants and types for the triangle linear basis setup block.
// No dependencies; imported by the top level, the square-root and the divider pipelines.
package tlbs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int N_COORDS        = 9;
	localparam int LANES           = 3;

	// result row codes
	localparam logic [1:0] ROW_A      = 2'd0;
	localparam logic [1:0] ROW_B      = 2'd1;
	localparam logic [1:0] ROW_C      = 2'd2;
	localparam logic [1:0] ROW_NORMAL = 2'd3;

	// pipeline control: global advance and valid of the entering transaction
	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

// ===== rtl/tlbs_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on tlbs_pkg (pipe_ctl_t).
module tlbs_sqrt import tlbs_pkg::*; #(
	parameter int RW     = 67,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pipe_ctl_t         ctl,
	input  logic [2*RW-1:0]   rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [RW-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);

	logic [RW-1:0]     v_s;
	logic [RW+2:0]     rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [2*RW-1:0]   rad_s  [RW];
	logic [SIDE_W-1:0] side_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		logic [RW+2:0]     rem_in;
		logic [RW-1:0]     root_in;
		logic [2*RW-1:0]   rad_in;
		logic [SIDE_W-1:0] side_i;
		logic              v_in;
		logic [RW+2:0]     cand;
		logic [RW+2:0]     trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign side_i  = side_in;
			assign v_in    = ctl.vld;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign rad_in  = rad_s[j-1];
			assign side_i  = side_s[j-1];
			assign v_in    = v_s[j-1];
		end

		// bring down the next two radicand bits, try (root << 2) | 1
		assign cand  = {rem_in[RW:0], rad_in[2*RW-1 -: 2]};
		assign trial = (RW+3)'({root_in, 2'b01});
		assign ge    = (cand >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (ctl.en) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[j]  <= ge ? (cand - trial) : cand;
				root_s[j] <= {root_in[RW-2:0], ge};
				rad_s[j]  <= rad_in << 2;
				side_s[j] <= side_i;
			end
		end
	end

	assign vld_out  = v_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule

// ===== rtl/tlbs_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage after the first.
// Depends on tlbs_pkg (pipe_ctl_t, LANES).
module tlbs_div import tlbs_pkg::*; #(
	parameter int UW     = 82,
	parameter int RW     = 67,
	parameter int VW     = 32,
	parameter int SIDE_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pipe_ctl_t         ctl,
	input  logic [RW-1:0]     den,
	input  logic [UW-1:0]     num [LANES],
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [RW-1:0]     den_out,
	output logic [VW-2:0]     quo [LANES],
	output logic [LANES-1:0]  ovf,
	output logic [SIDE_W-1:0] side_out
);

	localparam int XW  = (UW > RW + VW - 1) ? UW : RW + VW - 1;
	localparam int NST = VW;

	logic [NST-1:0]    v_s;
	logic [RW-1:0]     den_s  [NST];
	logic [SIDE_W-1:0] side_s [NST];
	logic [LANES-1:0]  ovf_s  [NST];
	logic [UW-1:0]     rem_s  [NST][LANES];
	logic [VW-2:0]     q_s    [NST][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ctl.en) begin
			v_s[0] <= ctl.vld;
		end
	end

	// first stage: flag quotients that cannot fit below 2^(VW-1)
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= num[l];
				q_s[0][l]   <= '0;
				ovf_s[0][l] <= (XW'(num[l]) >= (XW'(den) << (VW - 1)));
			end
		end
	end

	for (genvar k = 1; k < NST; k++) begin : g_stage
		localparam int B = VW - 1 - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ctl.en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [XW-1:0] trial;
			logic [XW-1:0] diff;
			logic          ge;

			assign trial = XW'(den_s[k-1]) << B;
			assign diff  = XW'(rem_s[k-1][l]) - trial;
			assign ge    = (XW'(rem_s[k-1][l]) >= trial);

			always_ff @(posedge clk) begin
				if (ctl.en) begin
					rem_s[k][l] <= ge ? diff[UW-1:0] : rem_s[k-1][l];
					q_s[k][l]   <= {q_s[k-1][l][VW-3:0], ge};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = q_s[NST-1][l];
		end
	end

	assign vld_out  = v_s[NST-1];
	assign den_out  = den_s[NST-1];
	assign ovf      = ovf_s[NST-1];
	assign side_out = side_s[NST-1];

endmodule

// ===== rtl/triangle_linear_basis_setup.sv =====
// Linear triangle setup: shape function coefficients, unit normal and doubled area.
// Rows 0 to 3 of a triangle leave in order after the setup stages, the square-root and the
// divider pipelines and the output register; one result row per cycle while the output
// skid slot is free, and a new triangle is taken as the last row of the one before issues.
// Each row walks a 2*COORD_WIDTH+3 stage square-root pipeline and a COORD_WIDTH stage divider pipeline.
// Reset (arst_n low, asynchronous): all valids clear, flip_normal clears; no memory to sweep.
module triangle_linear_basis_setup import tlbs_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int AW  = (COORD_WIDTH + FRAC_BITS > 64) ? 64 : COORD_WIDTH + FRAC_BITS,
	localparam int ITW = ((N_COORDS * COORD_WIDTH + 7) / 8) * 8,
	localparam int OTW = ((3 * COORD_WIDTH + AW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
	input  logic [ITW-1:0] s_tdata,
	input  logic           cfg_wen,
	input  logic           cfg_wdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// first_value, second_value, third_value, doubled_area, zero fill
	output logic [OTW-1:0] m_tdata,
	// row_index[1:0], degenerate
	output logic [2:0]     m_tuser,
	output logic           m_tlast
);

	localparam int CW   = COORD_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int VW   = CW;
	localparam int DW   = CW + 1;          // corner differences
	localparam int PW   = 2 * DW;          // products of differences
	localparam int NW   = PW + 1;          // signed normal component
	localparam int NMAG = NW - 1;          // normal magnitude
	localparam int H    = NMAG / 2;        // half width for squaring
	localparam int SW   = 2 * NMAG + 2;    // squared length
	localparam int RW   = SW / 2;          // root
	localparam int KW   = 2 * CW + 1;      // signed cofactor
	localparam int KMAG = 2 * CW;
	localparam int U1   = NMAG + FB;
	localparam int U2   = DW + 2 * FB;
	localparam int UW   = (U1 > U2) ? U1 : U2;   // numerator magnitude
	localparam int RSW  = RW - FB;
	localparam int SQ_SIDE = LANES * UW + LANES + 3;
	localparam int DV_SIDE = LANES + 3;
	localparam int EW   = 3 * VW + AW + 4;

	// configuration
	logic flip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (cfg_wen) begin
			flip_q <= cfg_wdata;
		end
	end

	// global advance: the whole pipeline moves while the output skid slot is free
	logic adv;
	logic e0_v_q, e1_v_q;

	assign adv = !e1_v_q;

	// ---------------------------------------------------------------------------
	// Stage 0: hold the triangle while its four rows issue; while the pipeline advances, one row per cycle
	// ---------------------------------------------------------------------------
	logic signed [CW-1:0] crd_q [N_COORDS];
	logic [1:0]           row_q;
	logic                 v0_q;
	logic                 s_acc;

	assign s_tready = adv && (!v0_q || row_q == ROW_NORMAL);
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q  <= 1'b0;
			row_q <= ROW_A;
		end else if (adv) begin
			if (s_acc) begin
				v0_q  <= 1'b1;
				row_q <= ROW_A;
			end else if (v0_q && row_q != ROW_NORMAL) begin
				row_q <= row_q + 2'd1;
			end else begin
				v0_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			for (int k = 0; k < N_COORDS; k++) begin
				crd_q[k] <= s_tdata[k*CW +: CW];
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 1: edge vectors and the corner pair of the current row
	// ---------------------------------------------------------------------------
	logic signed [CW-1:0] pix, piy, pjx, pjy;

	always_comb begin
		unique case (row_q)
			ROW_A: begin
				pix = crd_q[3]; piy = crd_q[4]; pjx = crd_q[6]; pjy = crd_q[7];
			end
			ROW_B: begin
				pix = crd_q[6]; piy = crd_q[7]; pjx = crd_q[0]; pjy = crd_q[1];
			end
			ROW_C: begin
				pix = crd_q[0]; piy = crd_q[1]; pjx = crd_q[3]; pjy = crd_q[4];
			end
			ROW_NORMAL: begin
				pix = crd_q[3]; piy = crd_q[4]; pjx = crd_q[6]; pjy = crd_q[7];
			end
			default: begin
				pix = crd_q[3]; piy = crd_q[4]; pjx = crd_q[6]; pjy = crd_q[7];
			end
		endcase
	end

	logic signed [DW-1:0] d1_s1 [3];
	logic signed [DW-1:0] d2_s1 [3];
	logic signed [CW-1:0] pix_s1, piy_s1, pjx_s1, pjy_s1;
	logic [1:0]           row_s1;
	logic                 v_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				d1_s1[c] <= DW'(crd_q[3+c]) - DW'(crd_q[c]);
				d2_s1[c] <= DW'(crd_q[6+c]) - DW'(crd_q[c]);
			end
			pix_s1 <= pix;
			piy_s1 <= piy;
			pjx_s1 <= pjx;
			pjy_s1 <= pjy;
			row_s1 <= row_q;
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 2: cross product terms, cofactor products, gradient differences
	// ---------------------------------------------------------------------------
	logic signed [PW-1:0]   na_s2 [3];
	logic signed [PW-1:0]   nb_s2 [3];
	logic signed [KMAG-1:0] ka_s2, kb_s2;
	logic signed [DW-1:0]   gx_s2, gy_s2;
	logic [1:0]             row_s2;
	logic                   v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s2[0] <= d1_s1[1] * d2_s1[2];
			nb_s2[0] <= d2_s1[1] * d1_s1[2];
			na_s2[1] <= d2_s1[0] * d1_s1[2];
			nb_s2[1] <= d1_s1[0] * d2_s1[2];
			na_s2[2] <= d1_s1[0] * d2_s1[1];
			nb_s2[2] <= d2_s1[0] * d1_s1[1];
			ka_s2    <= pix_s1 * pjy_s1;
			kb_s2    <= piy_s1 * pjx_s1;
			gx_s2    <= DW'(piy_s1) - DW'(pjy_s1);
			gy_s2    <= DW'(pjx_s1) - DW'(pix_s1);
			row_s2   <= row_s1;
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 3: normal components and cofactor
	// ---------------------------------------------------------------------------
	logic signed [NW-1:0] n_s3 [3];
	logic signed [KW-1:0] k_s3;
	logic signed [DW-1:0] gx_s3, gy_s3;
	logic [1:0]           row_s3;
	logic                 v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				n_s3[c] <= NW'(na_s2[c]) - NW'(nb_s2[c]);
			end
			k_s3   <= KW'(ka_s2) - KW'(kb_s2);
			gx_s3  <= gx_s2;
			gy_s3  <= gy_s2;
			row_s3 <= row_s2;
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 4: magnitudes, signs and the three numerators of this row
	// ---------------------------------------------------------------------------
	logic [NW-1:0]  n_abs [3];
	logic [KW-1:0]  k_abs;
	logic [DW-1:0]  gx_abs, gy_abs;
	logic           is_norm;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			n_abs[c] = n_s3[c][NW-1] ? NW'(-n_s3[c]) : NW'(n_s3[c]);
		end
		k_abs   = k_s3[KW-1] ? KW'(-k_s3) : KW'(k_s3);
		gx_abs  = gx_s3[DW-1] ? DW'(-gx_s3) : DW'(gx_s3);
		gy_abs  = gy_s3[DW-1] ? DW'(-gy_s3) : DW'(gy_s3);
		is_norm = (row_s3 == ROW_NORMAL);
	end

	logic [NMAG-1:0]  nm_s4 [3];
	logic [UW-1:0]    num_s4 [LANES];
	logic [LANES-1:0] sgn_s4;
	logic             dg_s4;
	logic [1:0]       row_s4;
	logic             v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				nm_s4[c] <= n_abs[c][NMAG-1:0];
			end
			num_s4[0] <= is_norm ? (UW'(n_abs[0][NMAG-1:0]) << FB) : (UW'(k_abs[KMAG-1:0]) << FB);
			num_s4[1] <= is_norm ? (UW'(n_abs[1][NMAG-1:0]) << FB) : (UW'(gx_abs) << (2 * FB));
			num_s4[2] <= is_norm ? (UW'(n_abs[2][NMAG-1:0]) << FB) : (UW'(gy_abs) << (2 * FB));
			// normal row: negate on flip by inverting the quotient sign
			sgn_s4[0] <= is_norm ? (n_s3[0][NW-1] ^ flip_q) : k_s3[KW-1];
			sgn_s4[1] <= is_norm ? (n_s3[1][NW-1] ^ flip_q) : gx_s3[DW-1];
			sgn_s4[2] <= is_norm ? (n_s3[2][NW-1] ^ flip_q) : gy_s3[DW-1];
			dg_s4     <= (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
			row_s4    <= row_s3;
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 5: square each normal magnitude in half-width partial products
	// ---------------------------------------------------------------------------
	logic [2*H-1:0]   hh_s5 [3];
	logic [2*H-1:0]   hl_s5 [3];
	logic [2*H-1:0]   ll_s5 [3];
	logic [SQ_SIDE-1:0] sd_s5;
	logic               v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				hh_s5[c] <= nm_s4[c][NMAG-1:H] * nm_s4[c][NMAG-1:H];
				hl_s5[c] <= nm_s4[c][NMAG-1:H] * nm_s4[c][H-1:0];
				ll_s5[c] <= nm_s4[c][H-1:0] * nm_s4[c][H-1:0];
			end
			sd_s5 <= {num_s4[2], num_s4[1], num_s4[0], sgn_s4, dg_s4, row_s4};
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 6: assemble the squares; Stage 7: sum them
	// ---------------------------------------------------------------------------
	logic [4*H-1:0]     sq_s6 [3];
	logic [SQ_SIDE-1:0] sd_s6;
	logic               v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				sq_s6[c] <= ((4*H)'(hh_s5[c]) << (2 * H)) + ((4*H)'(hl_s5[c]) << (H + 1))
					+ (4*H)'(ll_s5[c]);
			end
			sd_s6 <= sd_s5;
		end
	end

	logic [SW-1:0]      rad_s7;
	logic [SQ_SIDE-1:0] sd_s7;
	logic               v_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			sd_s7  <= sd_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v0_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ---------------------------------------------------------------------------
	// Square root of the squared normal length
	// ---------------------------------------------------------------------------
	pipe_ctl_t          sq_ctl;
	logic               sq_v;
	logic [RW-1:0]      sq_root;
	logic [SQ_SIDE-1:0] sq_side;

	assign sq_ctl = '{en: adv, vld: v_s7};

	tlbs_sqrt #(
		.RW     (RW),
		.SIDE_W (SQ_SIDE)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sq_ctl),
		.rad      (rad_s7),
		.side_in  (sd_s7),
		.vld_out  (sq_v),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// ---------------------------------------------------------------------------
	// Three quotients by the root
	// ---------------------------------------------------------------------------
	pipe_ctl_t          dv_ctl;
	logic [UW-1:0]      dv_num [LANES];
	logic [DV_SIDE-1:0] dv_side_in;
	logic               dv_v;
	logic [RW-1:0]      dv_root;
	logic [VW-2:0]      dv_quo [LANES];
	logic [LANES-1:0]   dv_ovf;
	logic [DV_SIDE-1:0] dv_side;

	assign dv_ctl = '{en: adv, vld: sq_v};

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			dv_num[l] = sq_side[DV_SIDE + l*UW +: UW];
		end
		dv_side_in = sq_side[DV_SIDE-1:0];
	end

	tlbs_div #(
		.UW     (UW),
		.RW     (RW),
		.VW     (VW),
		.SIDE_W (DV_SIDE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dv_ctl),
		.den      (sq_root),
		.num      (dv_num),
		.side_in  (dv_side_in),
		.vld_out  (dv_v),
		.den_out  (dv_root),
		.quo      (dv_quo),
		.ovf      (dv_ovf),
		.side_out (dv_side)
	);

	// ---------------------------------------------------------------------------
	// Result formation: sign, saturation, area
	// ---------------------------------------------------------------------------
	logic [1:0]       r_row;
	logic             r_dg;
	logic [LANES-1:0] r_sgn;
	logic [VW-1:0]    r_val [LANES];
	logic [AW-1:0]    r_area_sat;
	logic [AW-1:0]    r_area;
	logic [RSW-1:0]   r_rsh;
	logic [EW-1:0]    ent;

	assign r_row = dv_side[1:0];
	assign r_dg  = dv_side[2];
	assign r_sgn = dv_side[DV_SIDE-1:3];
	assign r_rsh = dv_root[RW-1:FB];

	if (RSW > AW) begin : g_area_sat
		assign r_area_sat = (|r_rsh[RSW-1:AW]) ? '1 : r_rsh[AW-1:0];
	end else begin : g_area_fit
		assign r_area_sat = AW'(r_rsh);
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (r_dg) begin
				r_val[l] = '0;
			end else if (dv_ovf[l]) begin
				r_val[l] = r_sgn[l] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
			end else if (r_sgn[l]) begin
				r_val[l] = VW'(-VW'(dv_quo[l]));
			end else begin
				r_val[l] = VW'(dv_quo[l]);
			end
		end
		r_area = r_dg ? '0 : r_area_sat;
		ent    = {(r_row == ROW_NORMAL), r_dg, r_row, r_area, r_val[2], r_val[1], r_val[0]};
	end

	// ---------------------------------------------------------------------------
	// Output register plus skid slot
	// ---------------------------------------------------------------------------
	logic [EW-1:0] e0_q, e1_q;
	logic          push, pop;

	assign push = adv && dv_v;
	assign pop  = e0_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_v_q <= 1'b0;
			e1_v_q <= 1'b0;
		end else if (pop) begin
			if (e1_v_q) begin
				e1_v_q <= 1'b0;
			end else begin
				e0_v_q <= push;
			end
		end else if (push) begin
			if (!e0_v_q) begin
				e0_v_q <= 1'b1;
			end else begin
				e1_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (e1_v_q) begin
				e0_q <= e1_q;
			end else begin
				e0_q <= ent;
			end
		end else if (push) begin
			if (!e0_v_q) begin
				e0_q <= ent;
			end else begin
				e1_q <= ent;
			end
		end
	end

	assign m_tvalid = e0_v_q;
	assign m_tdata  = OTW'(e0_q[3*VW+AW-1:0]);
	assign m_tuser  = e0_q[3*VW+AW+2 : 3*VW+AW];
	assign m_tlast  = e0_q[EW-1];

	// ---------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		e1_v_q |-> e0_v_q)
		else $error("skid slot holds a transaction while the output register is empty");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v0_q && row_q != ROW_NORMAL |=> v0_q && row_q == 2'($past(row_q) + 2'd1))
		else $error("row issue skipped or repeated a row");

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(row_q) && $stable(v0_q))
		else $error("row issue moved during a stall");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata[3*VW+AW-1:3*VW] == '0 && m_tdata[3*VW-1:0] == '0)
		else $error("degenerate row carries nonzero values");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for triangle_linear_basis_setup: streams triangles, predicts
// the four result rows with exact wide integer arithmetic and compares them in order.
// Depends on rtl/tlbs_pkg.sv and rtl/triangle_linear_basis_setup.sv.
`timescale 1ns / 100ps

module tb;
	import tlbs_pkg::*;

	localparam int CW       = 32;
	localparam int FB       = 16;
	localparam int AW       = 48;
	localparam int ITW      = 288;
	localparam int OTW      = 144;
	localparam int IDLE_LIM = 20000;
	localparam int LONG_HOLD = 900;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [1:0]    row;
		logic [CW-1:0] v1, v2, v3;
		logic [AW-1:0] area;
		logic          degen;
		logic          last;
	} row_t;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           s_tvalid = 0;
	logic           s_tready;
	logic [ITW-1:0] s_tdata = '0;
	logic           cfg_wen = 0;
	logic           cfg_wdata = 0;
	logic           m_tvalid;
	logic           m_tready = 0;
	logic [OTW-1:0] m_tdata;
	logic [2:0]     m_tuser;
	logic           m_tlast;

	logic [ITW-1:0] tri_queue[$];   // triangles waiting to be offered
	row_t           row_queue[$];   // expected rows, oldest first
	logic           flip_sh = 0;    // shadow of flip_normal
	int             errors = 0;
	int             accepted_tris = 0;
	bit             taken = 0;      // the item on the bus was accepted at the last edge
	bit             long_hold_done = 0;

	triangle_linear_basis_setup i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic wide_t sx(logic [CW-1:0] v);
		return {{(256-CW){v[CW-1]}}, v};
	endfunction

	// truncate toward zero already done by the caller; clamp to the value width
	function automatic logic [CW-1:0] sat_val(wide_t x);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (CW-1)) - 1;
		lo = -(wide_t'(1) <<< (CW-1));
		if (x > hi) return hi[CW-1:0];
		else if (x < lo) return lo[CW-1:0];
		else return x[CW-1:0];
	endfunction

	// work out the four rows of one triangle and queue them
	task automatic predict_rows(logic [ITW-1:0] d);
		wide_t p[3][3];
		wide_t d1[3], d2[3], n[3];
		wide_t s, r, cand, cof, gx, gy, v, sh;
		logic  degen;
		logic [AW-1:0] area;
		row_t  o;
		int    i, j;
		for (int k = 0; k < 3; k++)
			for (int c = 0; c < 3; c++)
				p[k][c] = sx(d[(k*3+c)*CW +: CW]);
		for (int c = 0; c < 3; c++) begin
			d1[c] = p[1][c] - p[0][c];
			d2[c] = p[2][c] - p[0][c];
		end
		n[0] = d1[1]*d2[2] - d2[1]*d1[2];
		n[1] = d2[0]*d1[2] - d1[0]*d2[2];
		n[2] = d1[0]*d2[1] - d2[0]*d1[1];
		s = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
		degen = (s == 0);
		r = 0;
		for (int b = 127; b >= 0; b--) begin
			cand = r | (wide_t'(1) <<< b);
			if (cand*cand <= s) r = cand;
		end
		sh = r >>> FB;
		if (degen) area = '0;
		else if (sh >= (wide_t'(1) <<< AW)) area = '1;
		else area = sh[AW-1:0];
		for (int k = 0; k < 4; k++) begin
			o.row = k[1:0];
			o.v1 = '0; o.v2 = '0; o.v3 = '0;
			o.area = area;
			o.degen = degen;
			o.last = (k == 3);
			if (!degen) begin
				if (k < 3) begin
					i = (k + 1) % 3;
					j = (k + 2) % 3;
					cof = p[i][0]*p[j][1] - p[i][1]*p[j][0];
					gx = p[i][1] - p[j][1];
					gy = p[j][0] - p[i][0];
					o.v1 = sat_val((cof <<< FB) / r);
					o.v2 = sat_val((gx <<< (2*FB)) / r);
					o.v3 = sat_val((gy <<< (2*FB)) / r);
				end else begin
					v = (n[0] <<< FB) / r; if (flip_sh) v = -v; o.v1 = sat_val(v);
					v = (n[1] <<< FB) / r; if (flip_sh) v = -v; o.v2 = sat_val(v);
					v = (n[2] <<< FB) / r; if (flip_sh) v = -v; o.v3 = sat_val(v);
				end
			end
			row_queue.push_back(o);
		end
	endtask

	function automatic logic [ITW-1:0] pack_tri(logic [CW-1:0] c[9]);
		logic [ITW-1:0] d;
		d = '0;
		for (int k = 0; k < 9; k++) d[k*CW +: CW] = c[k];
		return d;
	endfunction

	function automatic logic [CW-1:0] small_coord();
		return CW'($signed($urandom_range(0, 8*65536)) - 4*65536);
	endfunction

	// random triangle: mostly well-formed ones of moderate size, some full range,
	// some collinear or repeated corners, some tiny ones that saturate
	function automatic logic [ITW-1:0] random_tri();
		logic [CW-1:0] c[9];
		int kind, m;
		kind = $urandom_range(0, 9);
		for (int k = 0; k < 9; k++) c[k] = small_coord();
		case (kind)
			0, 1: begin
				for (int k = 0; k < 9; k++) c[k] = $urandom;
			end
			2: begin
				// collinear: c = a + m*(b - a)
				m = $urandom_range(0, 4) - 2;
				for (int k = 0; k < 3; k++) c[6+k] = c[k] + CW'(m) * (c[3+k] - c[k]);
			end
			3: begin
				// corners a few LSB apart
				for (int k = 3; k < 9; k++) c[k] = c[k%3] + CW'($urandom_range(0, 6)) - 3;
			end
			4: begin
				for (int k = 0; k < 9; k++) c[k] = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			end
			5: begin
				// flat in z: unit-ish normal along z
				c[2] = c[5]; c[8] = c[5];
			end
			default: ;
		endcase
		return pack_tri(c);
	endfunction

	task automatic add_tri(logic [CW-1:0] c0, c1, c2, c3, c4, c5, c6, c7, c8);
		logic [CW-1:0] c[9];
		c = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
		tri_queue.push_back(pack_tri(c));
	endtask

	task automatic wait_idle();
		while (tri_queue.size() > 0 || s_tvalid || row_queue.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_flip(logic v);
		@(negedge clk);
		cfg_wen <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 0;
		flip_sh = v;
	endtask

	localparam logic [CW-1:0] ONE = 32'h00010000;
	localparam logic [CW-1:0] MAXC = 32'h7FFFFFFF;
	localparam logic [CW-1:0] MINC = 32'h80000000;

	// stimulus and phase control
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		write_flip(0);
		// directed part
		add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);                         // all corners equal
		add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0);                     // unit right triangle
		add_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0);                     // reversed winding
		add_tri(0, 0, 0, ONE, 0, 0, 0, 0, ONE);                     // xz plane
		add_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE);                     // yz plane
		add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);                         // one LSB: saturation
		add_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);       // collinear
		add_tri(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0); // extremes
		add_tri(MINC, MINC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC);
		add_tri(MINC, 0, MAXC, MAXC, MINC, 0, 0, MAXC, MINC);
		add_tri('1, '1, '1, 0, 0, 0, MAXC, MAXC, MAXC);
		add_tri(MAXC, MINC, 0, MAXC, MINC, 0, MAXC, MINC, 0);      // repeated extreme corner
		add_tri(5*ONE, -3*ONE, ONE, -ONE, 2*ONE, -7*ONE, 4*ONE, 4*ONE, 3*ONE);
		wait_idle();
		write_flip(1);
		tri_queue.push_back(tri_queue.size() == 0 ? pack_tri('{0, 0, 0, ONE, 0, 0, 0, ONE, 0}) : '0);
		add_tri(MAXC, MINC, MAXC, MINC, MAXC, MINC, 0, 0, 0);
		for (int k = 0; k < 120; k++) tri_queue.push_back(random_tri());
		wait_idle();
		write_flip(0);
		for (int k = 0; k < 120; k++) tri_queue.push_back(random_tri());
		wait_idle();
		write_flip(1);
		for (int k = 0; k < 120; k++) tri_queue.push_back(random_tri());
		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	// sender: bursts of random length, random gaps; hold an offered item until taken
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (s_tvalid && !taken) begin
			// keep offering the same transaction
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_tvalid <= 0;
		end else if (tri_queue.size() > 0 && arst_n) begin
			s_tvalid <= 1;
			s_tdata <= tri_queue[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 30);
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			s_tvalid <= 0;
		end
	end

	// receiver: stall mode changes every stretch; one long hold-off once the pipe is busy
	int mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (!long_hold_done && accepted_tris >= 40) begin
			long_hold_done <= 1;
			hold_left <= LONG_HOLD;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else begin
			if (mode_left == 0) begin
				mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (mode)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
		end
	endtask

	// monitor: predict on input transactions, compare output transactions in order
	int idle_cycles = 0;
	always @(posedge clk) begin
		row_t e;
		taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			predict_rows(s_tdata);
			void'(tri_queue.pop_front());
			accepted_tris++;
		end
		if (m_tvalid && m_tready) begin
			if (row_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected row, expected none, actual %h", $realtime, m_tdata);
			end else begin
				e = row_queue.pop_front();
				check_field("row_index", e.row, m_tuser[1:0]);
				check_field("first_value", e.v1, m_tdata[0 +: CW]);
				check_field("second_value", e.v2, m_tdata[CW +: CW]);
				check_field("third_value", e.v3, m_tdata[2*CW +: CW]);
				check_field("doubled_area", e.area, m_tdata[3*CW +: AW]);
				check_field("degenerate", e.degen, m_tuser[2]);
				check_field("last", e.last, m_tlast);
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/tlbs_pkg.sv
rtl/tlbs_sqrt.sv
rtl/tlbs_div.sv
rtl/triangle_linear_basis_setup.sv
dv/tb.sv
